// ----- rtl/hsie_pkg.sv -----
// ============================================================================
// hsie_pkg
// Shared types and constants for the hashed slot index engine: the command
// and result items, request and status codes, slot entry layout and the
// controller states.
// ============================================================================
package hsie_pkg;

    // TABLE_SLOTS must be a power of two; the slot is the low bits of the hash.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PAGE_BITS   = 20;
    localparam int ENTRY_W     = PAGE_BITS + 1;

    localparam int HASH_W      = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT  = 5;

    localparam int REQ_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int PAGE_OUT_W  = 20;
    localparam int SLOT_OUT_W  = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_DELETE = 2'd2
    } hsie_req_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OCCUPIED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } hsie_status_e;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW
    } hsie_state_e;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] key_byte;
        logic              key_last;
    } hsie_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_OUT_W-1:0] page_id;
        logic [SLOT_OUT_W-1:0] slot_index;
    } hsie_result_t;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
    } hsie_entry_t;

    // djb2 step: hash * 33 + byte, wrapping at 32 bits
    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        fold_byte = (h << HASH_SHIFT) + h + HASH_W'(b);
    endfunction

endpackage

// ----- rtl/hsie_ram.sv -----
// ============================================================================
// hsie_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module hsie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hashed_slot_index_engine_core.sv -----
// ============================================================================
// hashed_slot_index_engine_core
// djb2-hashed direct-mapped slot table: folds key bytes into a hash and
// inserts, finds or deletes the slot picked on the last byte.
// ============================================================================
// A key byte that is not the last is folded into the hash with busy low, so
// such bytes may be issued back to back. The last byte of a key starts a
// read-modify-write: the slot entry is read from the slot RAM in the cycle
// the byte is accepted and modified and written back in the next, with busy
// high; the result then appears on the result port for exactly one cycle,
// flagged by done, in the cycle after that. The result register is
// independent of the command side, so a new byte can be accepted while a
// result is shown. The receiver cannot stall results. After reset all the
// TABLE_SLOTS (1024) slot RAM entries are cleared one per cycle with busy high.
module hashed_slot_index_engine_core
    import hsie_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  hsie_cmd_t    cmd,
    output logic         done,
    output hsie_result_t result
);

    hsie_state_e state_reg, state_next;

    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [PAGE_BITS:0]   pages_used_reg, pages_used_next;
    logic [SLOT_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic                 done_reg, done_next;
    hsie_result_t         result_reg, result_next;

    logic [HASH_W-1:0]    hash_fold;
    logic                 accept;

    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    hsie_entry_t          ram_wdata;
    hsie_entry_t          ram_rdata;
    logic [ENTRY_W-1:0]   ram_rdata_raw;

    logic [HASH_W-1:0]    slot_wide;
    logic [HASH_W-1:0]    page_wide;
    logic [STATUS_W-1:0]  op_status;
    logic [PAGE_BITS-1:0] op_page;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign hash_fold = fold_byte(hash_reg, cmd.key_byte);
    assign ram_rdata = hsie_entry_t'(ram_rdata_raw);

    hsie_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ENTRY_W'(ram_wdata)),
        .raddr(hash_fold[SLOT_BITS-1:0]),
        .rdata(ram_rdata_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            hash_reg       <= HASH_SEED;
            pages_used_reg <= '0;
            clr_cnt_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            pages_used_reg <= pages_used_next;
            clr_cnt_reg    <= clr_cnt_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    // Modify the entry read for the current key, or write a cleared entry while clearing
    always_comb
    begin
        op_status       = ST_NOT_FOUND;
        op_page         = '0;
        pages_used_next = pages_used_reg;
        ram_wdata       = ram_rdata;
        ram_we          = 1'b0;
        if (state_reg == S_RMW)
        begin
            unique case (req_reg)
                REQ_INSERT:
                begin
                    priority if (ram_rdata.valid)
                    begin
                        op_status = ST_OCCUPIED;
                    end
                    else if (pages_used_reg[PAGE_BITS])
                    begin
                        op_status = ST_FULL;
                    end
                    else
                    begin
                        op_status       = ST_OK;
                        op_page         = pages_used_reg[PAGE_BITS-1:0];
                        pages_used_next = pages_used_reg + 1'b1;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.page  = pages_used_reg[PAGE_BITS-1:0];
                        ram_we          = 1'b1;
                    end
                end
                REQ_FIND:
                begin
                    if (ram_rdata.valid)
                    begin
                        op_status = ST_OK;
                        op_page   = ram_rdata.page;
                    end
                end
                REQ_DELETE:
                begin
                    if (ram_rdata.valid)
                    begin
                        op_status       = ST_OK;
                        ram_wdata.valid = 1'b0;
                        ram_we          = 1'b1;
                    end
                end
                default:
                begin
                    op_status = ST_NOT_FOUND;
                end
            endcase
        end
        else if (state_reg == S_CLEAR)
        begin
            ram_wdata = '0;
            ram_we    = 1'b1;
        end
    end

    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_reg;
    assign slot_wide = HASH_W'(slot_reg);
    assign page_wide = HASH_W'(op_page);

    always_comb
    begin
        state_next          = state_reg;
        hash_next           = hash_reg;
        clr_cnt_next        = clr_cnt_reg;
        slot_next           = slot_reg;
        req_next            = req_reg;
        done_next           = 1'b0;
        result_next         = result_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_BITS'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.key_last)
                    begin
                        hash_next  = HASH_SEED;
                        slot_next  = hash_fold[SLOT_BITS-1:0];
                        req_next   = cmd.req_type;
                        state_next = S_RMW;
                    end
                    else
                    begin
                        hash_next = hash_fold;
                    end
                end
            end
            S_RMW:
            begin
                done_next               = 1'b1;
                result_next.status      = op_status;
                result_next.page_id     = page_wide[PAGE_OUT_W-1:0];
                result_next.slot_index  = slot_wide[SLOT_OUT_W-1:0];
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows a read-modify-write cycle
    a_done_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RMW))
        else $error("result strobe without a table access");

    // The page counter saturates exactly at the page limit
    a_pages_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        pages_used_reg[PAGE_BITS] |-> (pages_used_reg[PAGE_BITS-1:0] == '0))
        else $error("page counter passed its limit");

    // The counter moves only on a successful insert
    a_pages_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pages_used_reg != $past(pages_used_reg)) |->
            (done && (result.status == ST_OK) && ($past(req_reg) == REQ_INSERT)))
        else $error("page counter moved without an insert");

    // No item is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("accept during clearing pass");

endmodule
